### rtl/rfd_pkg.sv
// shared types, constants and helpers of the rs232 frame deframer
`default_nettype none

package rfd_pkg;

    // data bits per frame, default
    localparam int DATA_BITS_DEF = 7;

    // field widths
    localparam int SAMPLE_W = 15;
    localparam int MARK_W   = 15;
    localparam int SPACE_W  = 14;
    localparam int CHAR_W   = 7;
    localparam int POS_W    = 4;

    // stream bus widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // configuration bus
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_MARK_THRESH  = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_SPACE_THRESH = 3'd4;

    // threshold reset values
    localparam logic signed [MARK_W-1:0] MARK_THRESH_RST  = -15'sd3000;
    localparam logic [SPACE_W-1:0]       SPACE_THRESH_RST = 14'd3000;

    // line level of one sample
    typedef enum logic [1:0] {
        LEVEL_SPACE = 2'd0,
        LEVEL_MARK  = 2'd1,
        LEVEL_BAD   = 2'd2
    } level_t;

    typedef struct packed {
        logic signed [MARK_W-1:0] mark_threshold_mv;
        logic [SPACE_W-1:0]       space_threshold_mv;
    } rfd_cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_mv;
        logic                       last_sample;
    } rfd_sample_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              frame_ok;
        logic              message_ok;
        logic              end_of_message;
    } rfd_result_t;

    // mark wins where both thresholds are met
    function automatic level_t classify(
        input logic signed [SAMPLE_W-1:0] mv,
        input rfd_cfg_t                   cfg
    );
        logic signed [SAMPLE_W-1:0] space_s;
        space_s = $signed({1'b0, cfg.space_threshold_mv});
        if (mv <= cfg.mark_threshold_mv) begin
            return LEVEL_MARK;
        end else if (mv >= space_s) begin
            return LEVEL_SPACE;
        end else begin
            return LEVEL_BAD;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/rfd_apb_regs.sv
// apb register file holding the mark and space thresholds
`default_nettype none

module rfd_apb_regs (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rfd_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [rfd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [rfd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    output rfd_pkg::rfd_cfg_t                      cfg
);

    logic signed [rfd_pkg::MARK_W-1:0] mark_reg;
    logic [rfd_pkg::SPACE_W-1:0]       space_reg;
    logic                              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark_reg  <= rfd_pkg::MARK_THRESH_RST;
            space_reg <= rfd_pkg::SPACE_THRESH_RST;
        end else if (wr_en) begin
            if (paddr == rfd_pkg::ADDR_MARK_THRESH) begin
                mark_reg <= $signed(pwdata[rfd_pkg::MARK_W-1:0]);
            end
            if (paddr == rfd_pkg::ADDR_SPACE_THRESH) begin
                space_reg <= pwdata[rfd_pkg::SPACE_W-1:0];
            end
        end
    end

    // read mux, mark threshold sign extended
    always_comb begin
        prdata = '0;
        if (paddr == rfd_pkg::ADDR_MARK_THRESH) begin
            prdata = rfd_pkg::APB_DATA_W'(mark_reg);
        end else if (paddr == rfd_pkg::ADDR_SPACE_THRESH) begin
            prdata = rfd_pkg::APB_DATA_W'(space_reg);
        end
    end

    assign cfg.mark_threshold_mv  = mark_reg;
    assign cfg.space_threshold_mv = space_reg;

endmodule

`default_nettype wire

### rtl/rfd_input_stage.sv
// input register for line samples
`default_nettype none

module rfd_input_stage (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire rfd_pkg::rfd_sample_t in_data,
    output logic                      stage_valid,
    output rfd_pkg::rfd_sample_t      stage_data,
    input  wire logic                 stage_take
);

    logic                 valid_reg;
    rfd_pkg::rfd_sample_t data_reg;

    // free, or being drained this cycle
    assign in_ready = !valid_reg || stage_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_data  = data_reg;

endmodule

`default_nettype wire

### rtl/rfd_frame_core.sv
// frame tracking state and registered result output
`default_nettype none

module rfd_frame_core #(
    parameter int DATA_BITS = rfd_pkg::DATA_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire rfd_pkg::rfd_cfg_t    cfg,
    input  wire logic                 stage_valid,
    input  wire rfd_pkg::rfd_sample_t stage_data,
    output logic                      stage_take,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output rfd_pkg::rfd_result_t      out_data
);

    localparam int FRAME_LEN = DATA_BITS + 3;
    localparam logic [rfd_pkg::POS_W-1:0] POS_STOP = rfd_pkg::POS_W'(FRAME_LEN - 1);

    logic [rfd_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [DATA_BITS-1:0]      shift_reg, shift_next;
    logic                      frame_fail_reg, frame_fail_next;
    logic                      msg_fail_reg, msg_fail_next;
    logic                      out_valid_reg, out_valid_next;
    rfd_pkg::rfd_result_t      out_data_reg, out_data_next;

    rfd_pkg::level_t           level;
    logic                      fail_now;
    logic [DATA_BITS-1:0]      shift_upd;
    logic                      ff_upd;
    logic                      mf_upd;
    logic [DATA_BITS+rfd_pkg::CHAR_W-1:0] char_ext;

    assign stage_take = stage_valid && (!out_valid_reg || out_ready);
    assign level      = rfd_pkg::classify(stage_data.sample_mv, cfg);

    // level check for the current frame slot
    always_comb begin
        fail_now  = 1'b0;
        shift_upd = shift_reg;
        if (pos_reg == '0) begin
            fail_now = (level != rfd_pkg::LEVEL_MARK);
        end else if (pos_reg == rfd_pkg::POS_W'(1)) begin
            fail_now = (level != rfd_pkg::LEVEL_SPACE);
        end else if (pos_reg < POS_STOP) begin
            fail_now = (level == rfd_pkg::LEVEL_BAD);
            for (int i = 0; i < DATA_BITS; i++) begin
                if (pos_reg == rfd_pkg::POS_W'(i + 2) && level == rfd_pkg::LEVEL_MARK) begin
                    shift_upd[i] = 1'b1;
                end
            end
        end else begin
            fail_now = (level != rfd_pkg::LEVEL_MARK);
        end
        ff_upd   = frame_fail_reg || fail_now;
        mf_upd   = msg_fail_reg || ff_upd;
        char_ext = {rfd_pkg::CHAR_W'(0), shift_upd};
    end

    // next state and result
    always_comb begin
        pos_next        = pos_reg;
        shift_next      = shift_reg;
        frame_fail_next = frame_fail_reg;
        msg_fail_next   = msg_fail_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        if (stage_take) begin
            out_valid_next = 1'b0;
            if (pos_reg >= POS_STOP) begin
                // frame end, with or without end of message
                out_valid_next               = 1'b1;
                out_data_next.character      = char_ext[rfd_pkg::CHAR_W-1:0];
                out_data_next.frame_ok       = !ff_upd;
                out_data_next.message_ok     = !mf_upd;
                out_data_next.end_of_message = stage_data.last_sample;
                pos_next        = '0;
                shift_next      = '0;
                frame_fail_next = 1'b0;
                msg_fail_next   = stage_data.last_sample ? 1'b0 : mf_upd;
            end else if (stage_data.last_sample) begin
                // message cut off mid frame
                out_valid_next               = 1'b1;
                out_data_next.character      = '0;
                out_data_next.frame_ok       = 1'b0;
                out_data_next.message_ok     = 1'b0;
                out_data_next.end_of_message = 1'b1;
                pos_next        = '0;
                shift_next      = '0;
                frame_fail_next = 1'b0;
                msg_fail_next   = 1'b0;
            end else begin
                pos_next        = pos_reg + rfd_pkg::POS_W'(1);
                shift_next      = shift_upd;
                frame_fail_next = ff_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            shift_reg      <= '0;
            frame_fail_reg <= 1'b0;
            msg_fail_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            shift_reg      <= shift_next;
            frame_fail_reg <= frame_fail_next;
            msg_fail_reg   <= msg_fail_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### rtl/rs232_frame_deframer.sv
// top level of the rs232 frame deframer
//
// The s_ stream takes one line sample per transaction: s_tdata holds the signed
// millivolt value, s_tlast marks the final sample of a message. Each sample is
// read as mark, space or invalid against the two thresholds of the apb port.
// A frame is DATA_BITS + 3 samples (idle, start, data lsb first, stop).
// At each frame end, or on a last sample in mid frame, one transaction leaves
// on the m_ stream with the character, frame_ok and message_ok; m_tlast is set
// on the result caused by the last sample.
// A sample accepted on the s_ stream passes the input register, then the result
// register, before its result raises m_tvalid. Throughput: one sample per cycle
// while the m_ receiver does not stall, set by the single pass from input
// register through the level compare and the frame state update into the
// result register.
// When the receiver stalls, the result register holds; the input register can
// still take one more sample if it is empty, then s_tready drops until the result leaves.
// Reset clears frame position, character, error flags and both stream valids
// and loads the thresholds with -3000 mV and 3000 mV.
`default_nettype none

module rs232_frame_deframer #(
    parameter int DATA_BITS = rfd_pkg::DATA_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // sample stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [rfd_pkg::S_TDATA_W-1:0]     s_tdata,   // [14:0] sample_mv
    input  wire logic                              s_tlast,   // last_sample
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [rfd_pkg::M_TDATA_W-1:0]     m_tdata,   // [6:0] character,
                                                              // [7] frame_ok,
                                                              // [8] message_ok
    output logic                                   m_tlast,   // end_of_message
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rfd_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [rfd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [rfd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready
);

    rfd_pkg::rfd_cfg_t    cfg;
    rfd_pkg::rfd_sample_t in_data;
    rfd_pkg::rfd_sample_t stage_data;
    rfd_pkg::rfd_result_t out_data;
    logic                 stage_valid;
    logic                 stage_take;

    assign in_data.sample_mv   = $signed(s_tdata[rfd_pkg::SAMPLE_W-1:0]);
    assign in_data.last_sample = s_tlast;

    rfd_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rfd_input_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_data     (in_data),
        .stage_valid (stage_valid),
        .stage_data  (stage_data),
        .stage_take  (stage_take)
    );

    rfd_frame_core #(
        .DATA_BITS (DATA_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .stage_valid (stage_valid),
        .stage_data  (stage_data),
        .stage_take  (stage_take),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (out_data)
    );

    // pack result fields, padded to whole bytes
    assign m_tdata = rfd_pkg::M_TDATA_W'({out_data.message_ok, out_data.frame_ok,
                                          out_data.character});
    assign m_tlast = out_data.end_of_message;

endmodule

`default_nettype wire

### rtl/rfd_checker.sv
// port level checks for the rs232 frame deframer, bound to the top level
`default_nettype none

module rfd_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [rfd_pkg::M_TDATA_W-1:0]     m_tdata,
    input wire logic                              m_tlast
);

    // no result and input ready straight out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("result valid or input not ready after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // message status can only be good on a good frame
    a_msg_implies_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tdata[7])
        else $error("message_ok without frame_ok");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[rfd_pkg::M_TDATA_W-1:9] == '0)
        else $error("nonzero padding in result");

endmodule

bind rs232_frame_deframer rfd_checker u_rfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
